// File: rtl/doid_pkg.sv
// Shared types and constants for the DER OBJECT IDENTIFIER decoder.
// No dependencies; used by every module of the block.
`default_nettype none

package doid_pkg;

    // widest long-form length field accepted, in bytes
    localparam int MAX_LENGTH_BYTES = 4;
    localparam int LEFT_W           = $clog2(MAX_LENGTH_BYTES + 1);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [7:0]  TAG_OID   = 8'h06;
    localparam logic [31:0] ARC1_BASE = 32'd40;
    localparam logic [31:0] ARC2_BASE = 32'd80;

    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_BAD_TAG      = 3'd1,
        ERR_INDEF        = 3'd2,
        ERR_LEN_OVER     = 3'd3,
        ERR_CONTENT_OVER = 3'd4,
        ERR_TOO_WIDE     = 3'd5,
        ERR_EMPTY        = 3'd6
    } t_err;

    typedef enum logic [2:0] {
        PH_TAG      = 3'd0,
        PH_LEN      = 3'd1,
        PH_LENBYTES = 3'd2,
        PH_CONTENT  = 3'd3,
        PH_SKIP     = 3'd4
    } t_phase;

    // one queue entry: one result, or the pair from the first subidentifier
    typedef struct packed {
        logic        two;
        logic [31:0] comp0;
        logic        fin0;
        t_err        err0;
        logic [31:0] comp1;
        logic        fin1;
    } t_entry;

    typedef struct packed {
        logic [31:0] comp;
        logic        fin;
        t_err        err;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/doid_front.sv
// Front end: parses tag, length and content bytes, forms result entries.
// Depends on doid_pkg.
`default_nettype none

module doid_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_end,
    output logic                 o_ready,
    input  wire logic            i_full,
    output logic                 o_push,
    output doid_pkg::t_entry     o_entry
);

    doid_pkg::t_phase                r_phase, n_phase;
    logic [doid_pkg::LEFT_W-1:0]     r_left, n_left;
    logic [31:0]                     r_lv, n_lv;
    logic [31:0]                     r_cl, n_cl;
    logic [31:0]                     r_acc, n_acc;
    logic                            r_first, n_first;

    logic            accept;
    logic            more;
    logic            last;
    logic [31:0]     acc_ext;
    logic [31:0]     short_len;
    logic [31:0]     lb_len;
    logic            fail;
    doid_pkg::t_err  fail_code;
    logic [31:0]     arc;
    logic [31:0]     rem;

    assign o_ready   = !i_full;
    assign accept    = i_valid && o_ready;
    assign more      = i_byte[7];
    assign last      = (r_cl == 32'd1);
    assign acc_ext   = {r_acc[24:0], i_byte[6:0]};
    assign short_len = {25'd0, i_byte[6:0]};
    assign lb_len    = {r_lv[23:0], i_byte};

    // first subidentifier split into arc and remainder
    always_comb begin
        if (acc_ext >= doid_pkg::ARC2_BASE) begin
            arc = 32'd2;
            rem = acc_ext - doid_pkg::ARC2_BASE;
        end else if (acc_ext >= doid_pkg::ARC1_BASE) begin
            arc = 32'd1;
            rem = acc_ext - doid_pkg::ARC1_BASE;
        end else begin
            arc = 32'd0;
            rem = acc_ext;
        end
    end

    // error classification of the current byte
    always_comb begin
        fail      = 1'b0;
        fail_code = doid_pkg::ERR_NONE;
        unique case (r_phase)
            doid_pkg::PH_TAG: begin
                if (i_byte != doid_pkg::TAG_OID) begin
                    fail = 1'b1; fail_code = doid_pkg::ERR_BAD_TAG;
                end else if (i_end) begin
                    fail = 1'b1; fail_code = doid_pkg::ERR_LEN_OVER;
                end
            end
            doid_pkg::PH_LEN: begin
                if (!i_byte[7]) begin
                    if (i_end) begin
                        fail      = 1'b1;
                        fail_code = (i_byte[6:0] == 7'd0) ? doid_pkg::ERR_EMPTY
                                                          : doid_pkg::ERR_CONTENT_OVER;
                    end else if (i_byte[6:0] == 7'd0) begin
                        fail = 1'b1; fail_code = doid_pkg::ERR_EMPTY;
                    end
                end else if (i_byte[6:0] == 7'd0) begin
                    fail = 1'b1; fail_code = doid_pkg::ERR_INDEF;
                end else if (i_byte[6:0] > 7'(doid_pkg::MAX_LENGTH_BYTES)) begin
                    fail = 1'b1; fail_code = doid_pkg::ERR_TOO_WIDE;
                end else if (i_end) begin
                    fail = 1'b1; fail_code = doid_pkg::ERR_LEN_OVER;
                end
            end
            doid_pkg::PH_LENBYTES: begin
                if (r_lv[31:24] != 8'd0) begin
                    fail = 1'b1; fail_code = doid_pkg::ERR_TOO_WIDE;
                end else if (i_end) begin
                    fail = 1'b1; fail_code = doid_pkg::ERR_LEN_OVER;
                end else if (r_left == doid_pkg::LEFT_W'(1) && lb_len == 32'd0) begin
                    fail = 1'b1; fail_code = doid_pkg::ERR_EMPTY;
                end
            end
            doid_pkg::PH_CONTENT: begin
                // a cut-off subidentifier wins over the early buffer end
                if (last && more) begin
                    fail = 1'b1; fail_code = doid_pkg::ERR_EMPTY;
                end else if (i_end && !last) begin
                    fail = 1'b1; fail_code = doid_pkg::ERR_CONTENT_OVER;
                end
            end
            default: begin
                fail      = 1'b0;
                fail_code = doid_pkg::ERR_NONE;
            end
        endcase
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        n_lv    = r_lv;
        n_cl    = r_cl;
        n_acc   = r_acc;
        n_first = r_first;
        if (accept) begin
            if (fail) begin
                n_phase = i_end ? doid_pkg::PH_TAG : doid_pkg::PH_SKIP;
                n_left  = '0;
                n_lv    = '0;
                n_cl    = '0;
                n_acc   = '0;
                n_first = 1'b0;
            end else begin
                unique case (r_phase)
                    doid_pkg::PH_TAG: begin
                        n_phase = doid_pkg::PH_LEN;
                    end
                    doid_pkg::PH_LEN: begin
                        if (!i_byte[7]) begin
                            n_lv    = short_len;
                            n_cl    = short_len;
                            n_acc   = '0;
                            n_first = 1'b0;
                            n_phase = doid_pkg::PH_CONTENT;
                        end else begin
                            n_left  = i_byte[doid_pkg::LEFT_W-1:0];
                            n_lv    = '0;
                            n_phase = doid_pkg::PH_LENBYTES;
                        end
                    end
                    doid_pkg::PH_LENBYTES: begin
                        n_lv   = lb_len;
                        n_left = r_left - doid_pkg::LEFT_W'(1);
                        if (r_left == doid_pkg::LEFT_W'(1)) begin
                            n_cl    = lb_len;
                            n_acc   = '0;
                            n_first = 1'b0;
                            n_phase = doid_pkg::PH_CONTENT;
                        end
                    end
                    doid_pkg::PH_CONTENT: begin
                        n_acc = more ? acc_ext : 32'd0;
                        n_cl  = r_cl - 32'd1;
                        if (!more) begin
                            n_first = 1'b1;
                        end
                        if (last) begin
                            n_phase = doid_pkg::PH_TAG;
                            n_lv    = '0;
                            n_acc   = '0;
                            n_first = 1'b0;
                        end
                    end
                    default: begin
                        if (i_end) begin
                            n_phase = doid_pkg::PH_TAG;
                        end
                    end
                endcase
            end
        end
    end

    // queue entry
    always_comb begin
        o_push  = accept && (fail || (r_phase == doid_pkg::PH_CONTENT && !more));
        o_entry = '0;
        if (fail) begin
            o_entry.fin0 = 1'b1;
            o_entry.err0 = fail_code;
        end else if (!r_first) begin
            o_entry.two   = 1'b1;
            o_entry.comp0 = arc;
            o_entry.err0  = doid_pkg::ERR_NONE;
            o_entry.comp1 = rem;
            o_entry.fin1  = last;
        end else begin
            o_entry.comp0 = acc_ext;
            o_entry.fin0  = last;
            o_entry.err0  = doid_pkg::ERR_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= doid_pkg::PH_TAG;
            r_left  <= '0;
            r_lv    <= '0;
            r_cl    <= '0;
            r_acc   <= '0;
            r_first <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_lv    <= n_lv;
            r_cl    <= n_cl;
            r_acc   <= n_acc;
            r_first <= n_first;
        end
    end

endmodule

`default_nettype wire

// File: rtl/doid_fifo.sv
// Short queue of result entries between the parser and the output stage.
// Depends on doid_pkg.
`default_nettype none

module doid_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire doid_pkg::t_entry  i_entry,
    input  wire logic              i_pop,
    output doid_pkg::t_entry       o_head,
    output logic                   o_full,
    output logic                   o_empty
);

    doid_pkg::t_entry              r_mem [doid_pkg::FIFO_DEPTH];
    logic [doid_pkg::FIFO_AW-1:0]  r_wr, n_wr;
    logic [doid_pkg::FIFO_AW-1:0]  r_rd, n_rd;
    logic [doid_pkg::FIFO_AW:0]    r_cnt, n_cnt;

    assign o_full  = (r_cnt == (doid_pkg::FIFO_AW + 1)'(doid_pkg::FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = i_push ? r_wr + doid_pkg::FIFO_AW'(1) : r_wr;
        n_rd  = i_pop  ? r_rd + doid_pkg::FIFO_AW'(1) : r_rd;
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + (doid_pkg::FIFO_AW + 1)'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - (doid_pkg::FIFO_AW + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// File: rtl/doid_back.sv
// Back end: unpacks queue entries into single results in an output register.
// Depends on doid_pkg.
`default_nettype none

module doid_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire doid_pkg::t_entry  i_head,
    input  wire logic              i_empty,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output doid_pkg::t_result      o_result
);

    logic                r_valid, n_valid;
    logic                r_sel, n_sel;
    doid_pkg::t_result   r_res;
    doid_pkg::t_result   pick;
    logic                load;

    assign load    = !i_empty && (!r_valid || i_ready);
    // second half of a pair leaves the entry at the head until it goes out
    assign o_pop   = load && (!i_head.two || r_sel);
    assign o_valid = r_valid;
    assign o_result = r_res;

    always_comb begin
        if (r_sel) begin
            pick.comp = i_head.comp1;
            pick.fin  = i_head.fin1;
            pick.err  = doid_pkg::ERR_NONE;
        end else begin
            pick.comp = i_head.comp0;
            pick.fin  = i_head.fin0;
            pick.err  = i_head.err0;
        end
        n_valid = load || (r_valid && !i_ready);
        n_sel   = load ? !o_pop : r_sel;
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= pick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sel   <= n_sel;
        end
    end

endmodule

`default_nettype wire

// File: rtl/der_oid_decoder.sv
// Top level of the DER OBJECT IDENTIFIER decoder.
// Depends on doid_pkg, doid_front, doid_fifo and doid_back.
//
//  channel   direction  tdata                              tlast
//  s_axis    in         [7:0] data_byte                    buffer_end
//  m_axis    out        [31:0] component, [34:32] error    final_component
//
// One encoded byte is taken per cycle while the queue is not full; the parser updates
// its state in that cycle. Each result leaves the output register in a cycle of its
// own, so the first subidentifier (two results) takes two output transfers.
// Reset is synchronous, active low, and clears parser state and the queue.
// A four-entry queue separates parser and output; the input stalls only when
// it is full.
`default_nettype none

module der_oid_decoder (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [7:0]   i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic         i_s_axis_tlast,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    output logic [39:0]       o_m_axis_tdata,   // [31:0] component, [34:32] error_code
    output logic              o_m_axis_tlast
);

    logic               push;
    logic               pop;
    logic               full;
    logic               empty;
    doid_pkg::t_entry   entry;
    doid_pkg::t_entry   head;
    doid_pkg::t_result  result;

    doid_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_byte  (i_s_axis_tdata),
        .i_end   (i_s_axis_tlast),
        .o_ready (o_s_axis_tready),
        .i_full  (full),
        .o_push  (push),
        .o_entry (entry)
    );

    doid_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full),
        .o_empty (empty)
    );

    doid_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_empty  (empty),
        .o_pop    (pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (result)
    );

    assign o_m_axis_tdata = {5'd0, result.err, result.comp};
    assign o_m_axis_tlast = result.fin;

endmodule

`default_nettype wire

// File: dv/doid_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the DER OID decoder: watches both stream channels, predicts the
// arcs and error results of every accepted byte and compares them in order.
// Depends on doid_pkg for the phase and error enums and the result struct.

module doid_checker
    import doid_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    input  wire logic         i_s_axis_tready,
    input  wire logic [7:0]   i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic         i_s_axis_tlast,
    input  wire logic         i_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    input  wire logic [39:0]  i_m_axis_tdata,   // [31:0] component, [34:32] error_code
    input  wire logic         i_m_axis_tlast,
    input  wire logic         i_close,
    output int unsigned       o_fails,
    output int unsigned       o_pending,
    output int unsigned       o_checked
);

    localparam int MAX_PRINTED = 40;

    // shadow of the decoder state
    t_phase      ph;
    logic [6:0]  len_left;
    logic [31:0] len_val;
    logic [31:0] content_left;
    logic [31:0] acc;
    logic        first_done;
    logic        closed;

    t_result arcs_due[$];

    initial begin
        o_fails   = 0;
        o_pending = 0;
        o_checked = 0;
        closed    = 1'b0;
    end

    task automatic report(input string msg);
        if (o_fails < MAX_PRINTED)
            $display("[%0t] FAIL: %s", $realtime, msg);
        o_fails++;
    endtask

    task automatic clear_state();
        len_left     = '0;
        len_val      = '0;
        content_left = '0;
        acc          = '0;
        first_done   = 1'b0;
    endtask

    task automatic push_arc(input logic [31:0] comp, input logic fin, input t_err err);
        t_result r;
        r.comp = comp;
        r.fin  = fin;
        r.err  = err;
        arcs_due.insert(arcs_due.size(), r);
    endtask

    task automatic flag_error(input t_err err, input logic last);
        push_arc(32'd0, 1'b1, err);
        ph = last ? PH_TAG : PH_SKIP;
        clear_state();
    endtask

    task automatic open_content(input logic last);
        if (len_val == 32'd0) begin
            flag_error(ERR_EMPTY, last);
        end else begin
            content_left = len_val;
            acc          = '0;
            first_done   = 1'b0;
            ph           = PH_CONTENT;
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic last);
        logic        more;
        logic        done;
        logic [31:0] v;
        logic [31:0] arc;
        more = b[7];
        case (ph)
            PH_TAG: begin
                if (b != TAG_OID)
                    flag_error(ERR_BAD_TAG, last);
                else if (last)
                    flag_error(ERR_LEN_OVER, last);
                else
                    ph = PH_LEN;
            end
            PH_LEN: begin
                if (!b[7]) begin
                    len_val = {24'd0, b};
                    if (last) begin
                        if (b == 8'd0)
                            flag_error(ERR_EMPTY, last);
                        else
                            flag_error(ERR_CONTENT_OVER, last);
                    end else begin
                        open_content(last);
                    end
                end else if (b[6:0] == 7'd0) begin
                    flag_error(ERR_INDEF, last);
                end else if (int'(b[6:0]) > MAX_LENGTH_BYTES) begin
                    flag_error(ERR_TOO_WIDE, last);
                end else if (last) begin
                    flag_error(ERR_LEN_OVER, last);
                end else begin
                    len_left = b[6:0];
                    len_val  = '0;
                    ph       = PH_LENBYTES;
                end
            end
            PH_LENBYTES: begin
                if (len_val[31:24] != 8'd0) begin
                    flag_error(ERR_TOO_WIDE, last);
                end else if (last) begin
                    flag_error(ERR_LEN_OVER, last);
                end else begin
                    len_val  = {len_val[23:0], b};
                    len_left = len_left - 7'd1;
                    if (len_left == 7'd0)
                        open_content(last);
                end
            end
            PH_CONTENT: begin
                acc          = {acc[24:0], b[6:0]};
                content_left = content_left - 32'd1;
                done         = (content_left == 32'd0);
                // a cut-off subidentifier wins over the buffer running out
                if (done && more) begin
                    flag_error(ERR_EMPTY, last);
                end else if (last && !done) begin
                    flag_error(ERR_CONTENT_OVER, last);
                end else begin
                    if (!more) begin
                        if (!first_done) begin
                            v   = acc;
                            arc = 32'd0;
                            if (v >= ARC2_BASE) begin
                                arc = 32'd2;
                                v   = v - ARC2_BASE;
                            end else if (v >= ARC1_BASE) begin
                                arc = 32'd1;
                                v   = v - ARC1_BASE;
                            end
                            push_arc(arc, 1'b0, ERR_NONE);
                            push_arc(v, done, ERR_NONE);
                            first_done = 1'b1;
                        end else begin
                            push_arc(acc, done, ERR_NONE);
                        end
                        acc = '0;
                    end
                    if (done) begin
                        ph         = PH_TAG;
                        len_val    = '0;
                        acc        = '0;
                        first_done = 1'b0;
                    end
                end
            end
            default: begin
                if (last)
                    ph = PH_TAG;
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            ph = PH_TAG;
            clear_state();
            arcs_due.delete();
        end else begin
            // results leave a register, so they never stem from this edge's byte
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                o_checked++;
                if (arcs_due.size() == 0) begin
                    report($sformatf("unexpected result comp=%0h err=%0d fin=%0b",
                                     i_m_axis_tdata[31:0], i_m_axis_tdata[34:32],
                                     i_m_axis_tlast));
                end else begin
                    want = arcs_due.pop_front();
                    if (i_m_axis_tdata[31:0] != want.comp ||
                        i_m_axis_tdata[34:32] != want.err ||
                        i_m_axis_tlast != want.fin ||
                        i_m_axis_tdata[39:35] != 5'd0)
                        report($sformatf("got comp=%0h err=%0d fin=%0b pad=%0h, want comp=%0h err=%0d fin=%0b",
                                         i_m_axis_tdata[31:0], i_m_axis_tdata[34:32],
                                         i_m_axis_tlast, i_m_axis_tdata[39:35],
                                         want.comp, want.err, want.fin));
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                decode_byte(i_s_axis_tdata, i_s_axis_tlast);
        end
        if (i_close && !closed) begin
            closed = 1'b1;
            if (arcs_due.size() != 0)
                report($sformatf("%0d results never arrived", arcs_due.size()));
        end
        o_pending <= arcs_due.size();
    end

endmodule

// File: dv/tb_der_oid_decoder.sv
`timescale 1ns / 1ps
// Top of the DER OID decoder testbench: clock, reset, byte stimulus and output
// back-pressure. Depends on doid_pkg, der_oid_decoder and doid_checker.

module tb_der_oid_decoder;
    import doid_pkg::*;

    localparam int         N_ITEMS      = 2000;
    localparam int         CYCLE_LIMIT  = 1000000;
    localparam int         DRAIN_CYCLES = 40;
    localparam logic [7:0] LONG_FORM    = 8'h80;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = 8'd0;
    logic        s_tlast   = 1'b0;
    logic        m_tready  = 1'b0;
    logic        chk_close = 1'b0;
    wire logic        s_tready;
    wire logic        m_tvalid;
    wire logic [39:0] m_tdata;
    wire logic        m_tlast;

    int unsigned fails;
    int unsigned pending;
    int unsigned checked;
    int unsigned bytes_sent   = 0;
    int unsigned buffers_sent = 0;
    int unsigned cycles       = 0;
    logic        in_calm      = 1'b0;

    logic [7:0] octets[$];
    logic [7:0] body[$];

    der_oid_decoder uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    doid_checker chk (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_m_axis_tlast  (m_tlast),
        .i_close         (chk_close),
        .o_fails         (fails),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("der_oid_decoder: mismatch");
            $finish;
        end
    end

    function automatic int unsigned idle_len(input logic calm);
        idle_len = calm ? 0 : $urandom_range(0, 19);
    endfunction

    // output side: a random stall, possibly none, before each result transaction
    initial begin : result_sink
        int unsigned gap;
        int unsigned taken;
        logic        out_calm;
        taken    = 0;
        out_calm = 1'b0;
        forever begin
            if (taken % 32 == 0)
                out_calm = ($urandom_range(0, 3) == 0);
            gap = idle_len(out_calm);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
            taken++;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        gap = idle_len(in_calm);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
    endtask

    // sends the assembled octets; tlast only on the final one when asked
    task automatic send_run(input logic end_buffer);
        foreach (octets[i])
            send_byte(octets[i], end_buffer && (i == octets.size() - 1));
        octets.delete();
        if (end_buffer)
            buffers_sent++;
    endtask

    function automatic logic [34:0] any_arc();
        case ($urandom_range(0, 3))
            0:       any_arc = 35'($urandom_range(0, 127));
            1:       any_arc = 35'($urandom_range(0, 16383));
            2:       any_arc = 35'($urandom);
            default: any_arc = {3'($urandom_range(0, 7)), 32'($urandom)};  // wraps
        endcase
    endfunction

    // base-128, optionally with a redundant leading 0x80 group
    task automatic add_subid(input logic [34:0] v, input logic pad);
        int n;
        n = 1;
        while (n < 5 && (v >> (7 * n)) != 35'd0)
            n++;
        if (pad)
            n++;
        for (int k = n - 1; k >= 0; k--)
            body.insert(body.size(), {k != 0, 7'(v >> (7 * k))});
    endtask

    task automatic add_oid();
        int unsigned n;
        int unsigned root;
        int unsigned cnt;
        logic [34:0] first;
        body.delete();
        n    = $urandom_range(1, 6);
        root = $urandom_range(0, 2);
        if (root == 2)
            first = 35'(ARC2_BASE) + any_arc();
        else
            first = 35'(root == 1 ? ARC1_BASE : 32'd0) + 35'($urandom_range(0, 39));
        add_subid(first, $urandom_range(0, 7) == 0);
        for (int i = 1; i < n; i++)
            add_subid(any_arc(), $urandom_range(0, 7) == 0);
        octets.insert(octets.size(), TAG_OID);
        if ($urandom_range(0, 3) == 0) begin
            cnt = $urandom_range(1, MAX_LENGTH_BYTES);
            octets.insert(octets.size(), LONG_FORM | 8'(cnt));
            for (int k = cnt - 1; k >= 0; k--)
                octets.insert(octets.size(), 8'(body.size() >> (8 * k)));
        end else begin
            octets.insert(octets.size(), 8'(body.size()));
        end
        foreach (body[i])
            octets.insert(octets.size(), body[i]);
    endtask

    task automatic run_directed();
        // complete element, then a new tag without a buffer end in between
        octets = '{8'h06, 8'h01, 8'h2A};
        send_run(1'b0);
        octets = '{8'hFF};                          // wrong tag
        send_run(1'b1);
        octets = '{8'h06};                          // buffer ends after tag
        send_run(1'b1);
        octets = '{8'h06, 8'h80};                   // indefinite length
        send_run(1'b1);
        octets = '{8'h06, 8'h85};                   // length field too wide
        send_run(1'b1);
        octets = '{8'h06, 8'h00};                   // empty content
        send_run(1'b1);
        octets = '{8'h06, 8'h01, 8'hFF};            // subidentifier cut off
        send_run(1'b1);
        octets = '{8'h06, 8'h81, 8'h05};            // buffer ends in length
        send_run(1'b1);
        octets = '{8'h06, 8'h05, 8'h00};            // content overruns buffer
        send_run(1'b1);
        // long-form length, arc 2 and a full 32-bit first subidentifier
        octets = '{8'h06, 8'h81, 8'h05, 8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
        send_run(1'b1);
    endtask

    task automatic random_buffer();
        int unsigned kind;
        int unsigned n;
        int unsigned keep;
        in_calm = ($urandom_range(0, 3) == 0);
        kind    = $urandom_range(0, 99);
        if (kind < 70) begin
            n = $urandom_range(1, 3);
            repeat (n) add_oid();
            if ($urandom_range(0, 9) == 0) begin
                keep = $urandom_range(1, octets.size());
                while (octets.size() > keep)
                    void'(octets.pop_back());
            end
            send_run(1'b1);
        end else if (kind < 85) begin
            add_oid();
            case ($urandom_range(0, 2))
                0:       octets[$urandom_range(0, octets.size() - 1)] = 8'($urandom_range(0, 255));
                1:       octets[1] = LONG_FORM | 8'($urandom_range(0, 7));
                default: void'(octets.pop_back());
            endcase
            send_run(1'b1);
        end else begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) begin
                if (i == 0 && $urandom_range(0, 1) == 0)
                    send_byte(TAG_OID, 1'b0);
                else
                    send_byte(8'($urandom_range(0, 255)),
                              (i == n - 1) || ($urandom_range(0, 5) == 0));
            end
            buffers_sent++;
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        while (bytes_sent < N_ITEMS)
            random_buffer();
        s_tvalid <= 1'b0;
        // the pending count is registered, so let it take in the last byte first
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        chk_close <= 1'b1;
        repeat (2) @(posedge clk);
        $display("Sent %0d bytes in %0d buffers (well-formed, damaged and noise);",
                 bytes_sent, buffers_sent);
        $display("%0d result transactions compared, %0d failures.", checked, fails);
        if (fails == 0)
            $display("der_oid_decoder: match");
        else
            $display("der_oid_decoder: mismatch");
        $finish;
    end

endmodule
